>>> rtl/p2c_pkg.sv
// ----------------------------------------------------------------------------
// p2c_pkg
// Shared widths and reset values for the planar to chunky sprite decoder.
// ----------------------------------------------------------------------------
package p2c_pkg;

    localparam int PIXEL_W       = 5;
    localparam int ROW_OUT_W     = 4;
    localparam int SPRITE_IDX_W  = 10;
    localparam int COUNT_W       = 11;
    localparam int BYTE_W        = 8;
    localparam int PIXELS_PER_WORD = 8;

    localparam logic [COUNT_W-1:0] SPRITE_COUNT_RESET = COUNT_W'(10);

    typedef logic [PIXEL_W-1:0] pixel_t;

endpackage

>>> rtl/planar_to_chunky_sprite_decoder.sv
// ----------------------------------------------------------------------------
// planar_to_chunky_sprite_decoder
// Turns bit-plane sprite data plus a mask plane into 5-bit chunky pixels.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one plane byte (and its mask byte) per word, planes in order,
//   each plane covering the whole sprite row by row, left to right.
//   Bytes of the leading planes only fill the line store and give no word on
//   the m_ channel. Each last-plane byte gives one m_ word of eight pixels
//   with row, column group, sprite number and a last-of-sprite flag.
//   m_valid rises in the cycle after acceptance; the block takes one byte
//   every cycle while no last-plane byte waits on the output. The store read
//   for the next byte position is fetched ahead into a register, so the pixel
//   merge is a single level of bit selection feeding the output register.
//   When the receiver stalls, leading-plane bytes are still taken; a
//   last-plane byte waits until the output register is free or emptying.
//   cfg_wr_en writes sprite_count at once; write it only while idle.
//   Reset clears the counters and the output valid; sprite_count returns
//   to 10. The line store holds no reset and needs no clearing pass.
// ----------------------------------------------------------------------------
module planar_to_chunky_sprite_decoder
    import p2c_pkg::*;
#(
    parameter int SPRITE_WIDTH  = 16,
    parameter int SPRITE_HEIGHT = 16,
    parameter int COLOUR_PLANES = 4
) (
    input  logic                     aclk,
    input  logic                     aresetn,

    input  logic                     cfg_wr_en,
    input  logic [COUNT_W-1:0]       cfg_wr_data,

    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [BYTE_W-1:0]        s_plane_byte,
    input  logic [BYTE_W-1:0]        s_mask_byte,

    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [PIXEL_W-1:0]       m_pixel_0,
    output logic [PIXEL_W-1:0]       m_pixel_1,
    output logic [PIXEL_W-1:0]       m_pixel_2,
    output logic [PIXEL_W-1:0]       m_pixel_3,
    output logic [PIXEL_W-1:0]       m_pixel_4,
    output logic [PIXEL_W-1:0]       m_pixel_5,
    output logic [PIXEL_W-1:0]       m_pixel_6,
    output logic [PIXEL_W-1:0]       m_pixel_7,
    output logic [ROW_OUT_W-1:0]     m_row,
    output logic                     m_column_group,
    output logic [SPRITE_IDX_W-1:0]  m_sprite_index,
    output logic                     m_last_of_sprite
);

    localparam int GROUPS  = SPRITE_WIDTH / 8;
    localparam int BPP     = GROUPS * SPRITE_HEIGHT;
    localparam int POS_W   = (BPP > 1) ? $clog2(BPP) : 1;
    localparam int COL_W   = (GROUPS > 1) ? $clog2(GROUPS) : 1;
    localparam int ROW_W   = (SPRITE_HEIGHT > 1) ? $clog2(SPRITE_HEIGHT) : 1;
    localparam int PLANE_W = (COLOUR_PLANES > 1) ? $clog2(COLOUR_PLANES) : 1;
    localparam int STORED  = (COLOUR_PLANES > 1) ? COLOUR_PLANES - 1 : 1;

    logic [COUNT_W-1:0]      count_reg;
    logic [PLANE_W-1:0]      plane_reg,  plane_next;
    logic [POS_W-1:0]        pos_reg,    pos_next;
    logic [COL_W-1:0]        col_reg,    col_next;
    logic [ROW_W-1:0]        row_reg,    row_next;
    logic [SPRITE_IDX_W-1:0] sprite_reg, sprite_next;

    logic                    last_plane;
    logic                    s_accept;
    logic                    pos_end;
    logic [STORED*8-1:0]     store_rd;

    pixel_t                  pix_next [PIXELS_PER_WORD];
    pixel_t                  pix_reg  [PIXELS_PER_WORD];
    logic                    m_valid_reg;
    logic [ROW_OUT_W-1:0]    row_out_reg;
    logic                    col_out_reg;
    logic [SPRITE_IDX_W-1:0] sprite_out_reg;
    logic                    last_out_reg;

    assign last_plane = (plane_reg == PLANE_W'(COLOUR_PLANES - 1));
    assign s_ready    = !last_plane || !m_valid_reg || m_ready;
    assign s_accept   = s_valid && s_ready;
    assign pos_end    = (pos_reg == POS_W'(BPP - 1));

    // position, plane and sprite counters
    always_comb begin
        logic [COUNT_W-1:0] sprite_inc;
        sprite_inc  = COUNT_W'(sprite_reg) + COUNT_W'(1);
        plane_next  = plane_reg;
        pos_next    = pos_reg;
        col_next    = col_reg;
        row_next    = row_reg;
        sprite_next = sprite_reg;
        if (s_accept) begin
            if (pos_end) begin
                pos_next = '0;
                col_next = '0;
                row_next = '0;
                if (last_plane) begin
                    plane_next = '0;
                    if (sprite_inc >= count_reg) begin
                        sprite_next = '0;
                    end else begin
                        sprite_next = sprite_inc[SPRITE_IDX_W-1:0];
                    end
                end else begin
                    plane_next = plane_reg + PLANE_W'(1);
                end
            end else begin
                pos_next = pos_reg + POS_W'(1);
                if (col_reg == COL_W'(GROUPS - 1)) begin
                    col_next = '0;
                    row_next = row_reg + ROW_W'(1);
                end else begin
                    col_next = col_reg + COL_W'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg  <= SPRITE_COUNT_RESET;
            plane_reg  <= '0;
            pos_reg    <= '0;
            col_reg    <= '0;
            row_reg    <= '0;
            sprite_reg <= '0;
        end else begin
            if (cfg_wr_en) begin
                count_reg <= cfg_wr_data;
            end
            plane_reg  <= plane_next;
            pos_reg    <= pos_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
            sprite_reg <= sprite_next;
        end
    end

    if (COLOUR_PLANES > 1) begin : g_store
        // read address is the next byte position, so the fetch runs ahead of it
        p2c_plane_store #(
            .DEPTH   (BPP),
            .PLANES  (STORED),
            .ADDR_W  (POS_W),
            .PLANE_W (PLANE_W)
        ) u_store (
            .aclk     (aclk),
            .wr_en    (s_accept && !last_plane),
            .wr_plane (plane_reg),
            .wr_addr  (pos_reg),
            .wr_data  (s_plane_byte),
            .rd_addr  (pos_next),
            .rd_data  (store_rd)
        );
    end else begin : g_no_store
        assign store_rd = '0;
    end

    // bit interleave: plane p gives pixel bit p, mask sits above the colour
    always_comb begin
        logic [8:0] px;
        for (int k = 0; k < PIXELS_PER_WORD; k++) begin
            px = '0;
            for (int p = 0; p < COLOUR_PLANES - 1; p++) begin
                px[p] = store_rd[p*8 + 7 - k];
            end
            px[COLOUR_PLANES-1] = s_plane_byte[7-k];
            px[COLOUR_PLANES]   = s_mask_byte[7-k];
            pix_next[k] = px[PIXEL_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_accept && last_plane) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept && last_plane) begin
            pix_reg        <= pix_next;
            row_out_reg    <= ROW_OUT_W'((ROW_W + ROW_OUT_W)'(row_reg));
            col_out_reg    <= col_reg[0];
            sprite_out_reg <= sprite_reg;
            last_out_reg   <= pos_end;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_pixel_0        = pix_reg[0];
    assign m_pixel_1        = pix_reg[1];
    assign m_pixel_2        = pix_reg[2];
    assign m_pixel_3        = pix_reg[3];
    assign m_pixel_4        = pix_reg[4];
    assign m_pixel_5        = pix_reg[5];
    assign m_pixel_6        = pix_reg[6];
    assign m_pixel_7        = pix_reg[7];
    assign m_row            = row_out_reg;
    assign m_column_group   = (GROUPS > 1) ? col_out_reg : 1'b0;
    assign m_sprite_index   = sprite_out_reg;
    assign m_last_of_sprite = last_out_reg;

endmodule

>>> rtl/p2c_plane_store.sv
// ----------------------------------------------------------------------------
// p2c_plane_store
// Line store for the leading bit-planes: one byte-wide memory per stored
// plane, one write port and one registered read port shared by all planes.
// ----------------------------------------------------------------------------
module p2c_plane_store #(
    parameter int DEPTH   = 32,
    parameter int PLANES  = 3,
    parameter int ADDR_W  = 5,
    parameter int PLANE_W = 2
) (
    input  logic                  aclk,
    input  logic                  wr_en,
    input  logic [PLANE_W-1:0]    wr_plane,
    input  logic [ADDR_W-1:0]     wr_addr,
    input  logic [7:0]            wr_data,
    input  logic [ADDR_W-1:0]     rd_addr,
    output logic [PLANES*8-1:0]   rd_data
);

    for (genvar g = 0; g < PLANES; g++) begin : g_plane
        logic [7:0] mem [DEPTH];
        logic [7:0] rd_reg;
        logic       wr_hit;

        assign wr_hit = wr_en && (wr_plane == PLANE_W'(g));

        always_ff @(posedge aclk) begin
            if (wr_hit) begin
                mem[wr_addr] <= wr_data;
            end
        end

        // a write to the address being fetched goes straight through
        always_ff @(posedge aclk) begin
            if (wr_hit && (wr_addr == rd_addr)) begin
                rd_reg <= wr_data;
            end else begin
                rd_reg <= mem[rd_addr];
            end
        end

        assign rd_data[g*8 +: 8] = rd_reg;
    end

endmodule

>>> verif/p2c_scoreboard_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// p2c_scoreboard_pkg
// Predicts chunky pixel words from a stream of bit-plane bytes and checks
// the words that the decoder hands out, in order, field by field.
// ----------------------------------------------------------------------------
package p2c_scoreboard_pkg;

    import p2c_pkg::*;

    localparam int GROUPS_PER_ROW  = 2;
    localparam int BYTES_PER_PLANE = 32;
    localparam int PLANE_COUNT     = 4;

    typedef struct packed {
        logic [PIXELS_PER_WORD-1:0][PIXEL_W-1:0] pixels;
        logic [ROW_OUT_W-1:0]                    row;
        logic                                    column_group;
        logic [SPRITE_IDX_W-1:0]                 sprite_index;
        logic                                    last_of_sprite;
    } pixel_word_t;

    class chunky_pixel_scoreboard;

        bit [23:0]             line_store [BYTES_PER_PLANE];
        bit [1:0]              plane_now;
        bit [4:0]              byte_pos;
        bit [SPRITE_IDX_W-1:0] sprite_now;
        bit [COUNT_W-1:0]      sprite_total;
        pixel_word_t           words_due [$];
        int                    mismatches;
        int                    words_checked;
        int                    bytes_taken;
        int                    sprites_seen;

        function new();
            plane_now     = '0;
            byte_pos      = '0;
            sprite_now    = '0;
            sprite_total  = SPRITE_COUNT_RESET;
            mismatches    = 0;
            words_checked = 0;
            bytes_taken   = 0;
            sprites_seen  = 0;
        endfunction

        function void set_sprite_total(logic [COUNT_W-1:0] value);
            sprite_total = value;
        endfunction

        function int pending();
            return words_due.size();
        endfunction

        function void advance_position();
            if (byte_pos == BYTES_PER_PLANE - 1) begin
                byte_pos = '0;
                if (plane_now == PLANE_COUNT - 1) begin
                    plane_now = '0;
                    // a count of zero acts like one; the index wraps at 10 bits
                    if (int'(sprite_now) + 1 >= int'(sprite_total))
                        sprite_now = '0;
                    else
                        sprite_now = sprite_now + 1'b1;
                end else begin
                    plane_now = plane_now + 1'b1;
                end
            end else begin
                byte_pos = byte_pos + 1'b1;
            end
        endfunction

        function void note_plane_byte(logic [7:0] plane_byte, logic [7:0] mask_byte);
            pixel_word_t word;
            int          bitpos;
            if (plane_now != PLANE_COUNT - 1) begin
                line_store[byte_pos][int'(plane_now)*8 +: 8] = plane_byte;
            end else begin
                // msb of each byte is the leftmost pixel
                for (int k = 0; k < PIXELS_PER_WORD; k++) begin
                    bitpos = 7 - k;
                    word.pixels[k] = {mask_byte[bitpos], plane_byte[bitpos],
                                      line_store[byte_pos][16 + bitpos],
                                      line_store[byte_pos][8 + bitpos],
                                      line_store[byte_pos][bitpos]};
                end
                word.row            = ROW_OUT_W'(byte_pos / GROUPS_PER_ROW);
                word.column_group   = byte_pos[0];
                word.sprite_index   = sprite_now;
                word.last_of_sprite = (byte_pos == BYTES_PER_PLANE - 1);
                words_due.push_back(word);
            end
            bytes_taken++;
            advance_position();
        endfunction

        task report(string what, logic [31:0] got_val, logic [31:0] want_val);
            mismatches++;
            $display("mismatch on %s: got %0d, expected %0d (word %0d)",
                     what, got_val, want_val, words_checked);
        endtask

        task check_pixel_word(pixel_word_t got);
            pixel_word_t want;
            if (words_due.size() == 0) begin
                report("pixel word with none outstanding", 0, 0);
                return;
            end
            want = words_due.pop_front();
            for (int k = 0; k < PIXELS_PER_WORD; k++) begin
                if (got.pixels[k] !== want.pixels[k])
                    report($sformatf("pixel_%0d", k), got.pixels[k], want.pixels[k]);
            end
            if (got.row !== want.row)
                report("row", got.row, want.row);
            if (got.column_group !== want.column_group)
                report("column_group", got.column_group, want.column_group);
            if (got.sprite_index !== want.sprite_index)
                report("sprite_index", got.sprite_index, want.sprite_index);
            if (got.last_of_sprite !== want.last_of_sprite)
                report("last_of_sprite", got.last_of_sprite, want.last_of_sprite);
            if (want.last_of_sprite)
                sprites_seen++;
            words_checked++;
        endtask

    endclass

endpackage

>>> verif/tb_planar_to_chunky_sprite_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_planar_to_chunky_sprite_decoder
// Streams bit-plane and mask bytes into the decoder, with random idling on
// both sides and then none, across several sprite count settings, and checks
// every pixel word against a cycle-free prediction of the conversion.
// ----------------------------------------------------------------------------
module tb_planar_to_chunky_sprite_decoder;

    import p2c_pkg::*;
    import p2c_scoreboard_pkg::*;

    localparam int CYCLE_LIMIT = 200000;

    logic                    aclk;
    logic                    aresetn      = 1'b0;
    logic                    cfg_wr_en    = 1'b0;
    logic [COUNT_W-1:0]      cfg_wr_data  = '0;
    logic                    s_valid      = 1'b0;
    logic                    s_ready;
    logic [BYTE_W-1:0]       s_plane_byte = '0;
    logic [BYTE_W-1:0]       s_mask_byte  = '0;
    logic                    m_valid;
    logic                    m_ready      = 1'b0;
    logic [PIXEL_W-1:0]      m_pixel_0;
    logic [PIXEL_W-1:0]      m_pixel_1;
    logic [PIXEL_W-1:0]      m_pixel_2;
    logic [PIXEL_W-1:0]      m_pixel_3;
    logic [PIXEL_W-1:0]      m_pixel_4;
    logic [PIXEL_W-1:0]      m_pixel_5;
    logic [PIXEL_W-1:0]      m_pixel_6;
    logic [PIXEL_W-1:0]      m_pixel_7;
    logic [ROW_OUT_W-1:0]    m_row;
    logic                    m_column_group;
    logic [SPRITE_IDX_W-1:0] m_sprite_index;
    logic                    m_last_of_sprite;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int cycle_count   = 0;
    int settings_run  = 1;

    chunky_pixel_scoreboard sb;

    planar_to_chunky_sprite_decoder u_top (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_wr_data      (cfg_wr_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_plane_byte     (s_plane_byte),
        .s_mask_byte      (s_mask_byte),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_pixel_0        (m_pixel_0),
        .m_pixel_1        (m_pixel_1),
        .m_pixel_2        (m_pixel_2),
        .m_pixel_3        (m_pixel_3),
        .m_pixel_4        (m_pixel_4),
        .m_pixel_5        (m_pixel_5),
        .m_pixel_6        (m_pixel_6),
        .m_pixel_7        (m_pixel_7),
        .m_row            (m_row),
        .m_column_group   (m_column_group),
        .m_sprite_index   (m_sprite_index),
        .m_last_of_sprite (m_last_of_sprite)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d words outstanding",
                     cycle_count, sb.pending());
            $display("TB_ERROR");
            $finish;
        end
    end

    // receiver: samples the word at the edge, then picks next ready
    initial begin
        pixel_word_t got;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                got.pixels = {m_pixel_7, m_pixel_6, m_pixel_5, m_pixel_4,
                              m_pixel_3, m_pixel_2, m_pixel_1, m_pixel_0};
                got.row            = m_row;
                got.column_group   = m_column_group;
                got.sprite_index   = m_sprite_index;
                got.last_of_sprite = m_last_of_sprite;
                sb.check_pixel_word(got);
            end
            m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    task automatic send_plane_word(input logic [7:0] plane_byte, input logic [7:0] mask_byte);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_plane_byte <= plane_byte;
        s_mask_byte  <= mask_byte;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_plane_byte(plane_byte, mask_byte);
    endtask

    // one sprite of corner patterns: all-zero, all-one, walking bits and
    // a ramp through all sixteen colours; the tail of each plane is random
    function automatic logic [7:0] corner_plane_byte(int plane, int pos);
        logic [7:0] ramp [PLANE_COUNT] = '{8'h55, 8'h33, 8'h0F, 8'h00};
        if (pos == 0) return 8'h00;
        if (pos == 1) return 8'hFF;
        if (pos < 10) return 8'h01 << (pos - 2);
        if (pos < 18) return ~(8'h01 << (pos - 10));
        if (pos == 18) return ramp[plane];
        if (pos == 19) return (plane == PLANE_COUNT - 1) ? 8'hFF : ramp[plane];
        return 8'($urandom);
    endfunction

    function automatic logic [7:0] corner_mask_byte(int pos);
        if (pos == 0) return 8'hFF;
        if (pos == 1) return 8'h00;
        if (pos < 10) return 8'h80 >> (pos - 2);
        if (pos == 18) return 8'hF0;
        if (pos == 19) return 8'h0F;
        return 8'($urandom);
    endfunction

    task automatic send_corner_sprite();
        for (int i = 0; i < PLANE_COUNT * BYTES_PER_PLANE; i++)
            send_plane_word(corner_plane_byte(i / BYTES_PER_PLANE, i % BYTES_PER_PLANE),
                            corner_mask_byte(i % BYTES_PER_PLANE));
    endtask

    task automatic send_random_bytes(input int n_items);
        for (int i = 0; i < n_items; i++)
            send_plane_word(8'($urandom), 8'($urandom));
    endtask

    // leading-plane bytes give no word, so let the pipeline drain a bit more
    task automatic write_sprite_count(input logic [COUNT_W-1:0] value);
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        sb.set_sprite_total(value);
        settings_run++;
    endtask

    initial begin
        sb = new();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_idle_pct = 17;
        recv_idle_pct = 73;
        send_corner_sprite();
        // stop partway into sprite 4, then drop the count below it
        send_random_bytes(3 * 128 + 50);
        write_sprite_count(COUNT_W'(2));
        send_random_bytes(300);

        send_idle_pct = 73;
        recv_idle_pct = 17;
        write_sprite_count(COUNT_W'(0));
        send_random_bytes(260);
        write_sprite_count(COUNT_W'(1));
        send_random_bytes(150);
        write_sprite_count(COUNT_W'(2047));
        send_random_bytes(400);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_sprite_count(COUNT_W'(1024));
        send_random_bytes(200);
        write_sprite_count(COUNT_W'($urandom_range(3, 12)));
        send_random_bytes(150);

        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);

        $display("sent %0d plane bytes, checked %0d pixel words ending %0d sprites",
                 sb.bytes_taken, sb.words_checked, sb.sprites_seen);
        $display("sprite count settings: %0d incl. 0, 1, 1024, 2047; idle mixes 17/73, 73/17, none",
                 settings_run);
        if (sb.mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
